[design/asd_pkg.sv]
`timescale 1ns / 1ps

package asd_pkg;

	localparam int AXES         = 3;
	localparam int SAMPLE_W     = 16;
	localparam int VAL_W        = 18;
	localparam int WINDOW_W     = 16;
	localparam int EXT_W        = 17;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 17;
	localparam int SUM_TAPS_DEF = 4;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd50;
	localparam logic [EXT_W-1:0]    EXTREME_RESET = 17'd100;
	localparam logic [EXT_W-1:0]    CHANGE_RESET = 17'd100;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 18'sd131071;
	localparam logic signed [VAL_W-1:0] VAL_MIN = -18'sd131072;

	typedef logic [1:0] axis_code_t;
	localparam axis_code_t AXIS_X = 2'd0;
	localparam axis_code_t AXIS_Y = 2'd1;
	localparam axis_code_t AXIS_Z = 2'd2;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	localparam cfg_index_t CFG_WINDOW  = 2'd0;
	localparam cfg_index_t CFG_EXTREME = 2'd1;
	localparam cfg_index_t CFG_CHANGE  = 2'd2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [VAL_W-1:0]    val_t;

	typedef struct packed {
		logic en;
		logic reload;
	} axis_ctl_t;

	typedef struct packed {
		val_t thr;
		val_t fprev;
		val_t fnow;
	} axis_stat_t;

endpackage

[design/asd_axis.sv]
`timescale 1ns / 1ps

module asd_axis import asd_pkg::*; #(
	parameter int SUM_TAPS = SUM_TAPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sample_t          sample,
	input  axis_ctl_t        ctl,
	input  logic [EXT_W-1:0] extreme_init,
	input  logic [EXT_W-1:0] change_min,
	output axis_stat_t       stat
);

	localparam int SUM_W = VAL_W + $clog2(SUM_TAPS + 1);

	sample_t hist_q [SUM_TAPS];
	val_t    peak_high_q;
	val_t    peak_low_q;
	val_t    thr_q;
	val_t    fnow_q;

	logic signed [SUM_W-1:0] sum_wide;
	val_t                    sum_sat;
	val_t                    ph_upd;
	val_t                    pl_upd;
	logic signed [VAL_W:0]   half_sum;
	logic signed [VAL_W:0]   half_adj;
	val_t                    thr_next;
	val_t                    ext_pos;
	logic signed [VAL_W:0]   diff;
	logic [VAL_W:0]          diff_abs;
	val_t                    fnow_next;

	// Window sum over the new sample and the newest SUM_TAPS-1 held samples
	always_comb begin
		sum_wide = SUM_W'(sample);
		for (int k = 0; k < SUM_TAPS - 1; k++) begin
			sum_wide = sum_wide + SUM_W'(hist_q[k]);
		end
	end

	always_comb begin
		if (sum_wide > SUM_W'(VAL_MAX)) begin
			sum_sat = VAL_MAX;
		end else if (sum_wide < SUM_W'(VAL_MIN)) begin
			sum_sat = VAL_MIN;
		end else begin
			sum_sat = sum_wide[VAL_W-1:0];
		end
	end

	assign ph_upd = (sum_sat > peak_high_q) ? sum_sat : peak_high_q;
	assign pl_upd = (sum_sat < peak_low_q) ? sum_sat : peak_low_q;

	// Midpoint, truncated toward zero
	assign half_sum = {ph_upd[VAL_W-1], ph_upd} + {pl_upd[VAL_W-1], pl_upd};
	assign half_adj = half_sum + {{VAL_W{1'b0}}, half_sum[VAL_W]};
	assign thr_next = ctl.reload ? half_adj[VAL_W:1] : thr_q;
	assign ext_pos  = {1'b0, extreme_init};

	// Dead band on the filtered value
	assign diff     = {fnow_q[VAL_W-1], fnow_q} - {sum_sat[VAL_W-1], sum_sat};
	assign diff_abs = diff[VAL_W] ? (~diff + 1'b1) : diff;
	assign fnow_next = (diff_abs > {2'b00, change_min}) ? sum_sat : fnow_q;

	assign stat.thr   = thr_next;
	assign stat.fprev = fnow_q;
	assign stat.fnow  = fnow_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SUM_TAPS; k++) begin
				hist_q[k] <= '0;
			end
			peak_high_q <= '0;
			peak_low_q  <= '0;
			thr_q       <= '0;
			fnow_q      <= '0;
		end else if (ctl.en) begin
			hist_q[0] <= sample;
			for (int k = 1; k < SUM_TAPS; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
			if (ctl.reload) begin
				peak_high_q <= -ext_pos;
				peak_low_q  <= ext_pos;
			end else begin
				peak_high_q <= ph_upd;
				peak_low_q  <= pl_upd;
			end
			thr_q  <= thr_next;
			fnow_q <= fnow_next;
		end
	end

endmodule

[design/asd_select.sv]
`timescale 1ns / 1ps

module asd_select import asd_pkg::*; (
	input  axis_stat_t stat [AXES],
	output axis_code_t sel,
	output val_t       thr,
	output logic       step
);

	logic [VAL_W-1:0] mag [AXES];
	axis_stat_t       pick;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			mag[a] = stat[a].thr[VAL_W-1] ? (~stat[a].thr + 1'b1) : stat[a].thr;
		end
	end

	// x needs to beat both and y needs to beat z; a tie goes to the later axis
	always_comb begin
		if (mag[0] > mag[1]) begin
			sel = (mag[0] > mag[2]) ? AXIS_X : AXIS_Z;
		end else begin
			sel = (mag[1] > mag[2]) ? AXIS_Y : AXIS_Z;
		end
	end

	always_comb begin
		unique case (sel)
			AXIS_X:  pick = stat[0];
			AXIS_Y:  pick = stat[1];
			default: pick = stat[2];
		endcase
	end

	assign thr  = pick.thr;
	assign step = ($signed(pick.fprev) > $signed(pick.thr)) &&
	              ($signed(pick.fnow) < $signed(pick.thr));

endmodule

[design/accel_step_detector.sv]
`timescale 1ns / 1ps

// Step detector for a three-axis accelerometer. Every accepted sample gives
// exactly one result (step flag, active axis, its threshold), in order. The
// block takes one sample per clock cycle unless the result side stalls;
// the sample lands in the input register, then a single pass of window sum,
// peak tracking, threshold, dead-band filter and axis selection fills the
// result register when that register is empty or being read. Configuration
// writes are taken in any cycle on the cfg channel and should land only
// while no sample is in flight.
module accel_step_detector import asd_pkg::*; #(
	parameter int SUM_TAPS = SUM_TAPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sample_t                accel_x,
	input  sample_t                accel_y,
	input  sample_t                accel_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   step_seen,
	output axis_code_t             active_axis,
	output val_t                   active_threshold,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  cfg_index_t             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [WINDOW_W-1:0] window_q;
	logic [EXT_W-1:0]    extreme_q;
	logic [EXT_W-1:0]    change_q;
	logic [WINDOW_W-1:0] count_q;

	logic    valid_s1;
	sample_t samp_s1 [AXES];

	logic            out_valid_q;
	logic            step_q;
	axis_code_t      axis_q;
	val_t            thr_q;

	logic            advance;
	logic [WINDOW_W:0] count_inc;
	logic            window_hit;
	axis_ctl_t       ctl;
	axis_stat_t      stat [AXES];
	axis_code_t      sel;
	val_t            sel_thr;
	logic            step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RESET;
			extreme_q <= EXTREME_RESET;
			change_q  <= CHANGE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WINDOW:  window_q  <= cfg_data[WINDOW_W-1:0];
				CFG_EXTREME: extreme_q <= cfg_data[EXT_W-1:0];
				CFG_CHANGE:  change_q  <= cfg_data[EXT_W-1:0];
				default:     ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			samp_s1[0] <= accel_x;
			samp_s1[1] <= accel_y;
			samp_s1[2] <= accel_z;
		end
	end

	// Counter compared one bit wider, cleared when past the window
	assign count_inc  = {1'b0, count_q} + 1'b1;
	assign window_hit = count_inc > {1'b0, window_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= window_hit ? '0 : count_inc[WINDOW_W-1:0];
		end
	end

	assign ctl.en     = advance;
	assign ctl.reload = window_hit;

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		asd_axis #(
			.SUM_TAPS(SUM_TAPS)
		) u_axis (
			.clk         (clk),
			.arst_n      (arst_n),
			.sample      (samp_s1[a]),
			.ctl         (ctl),
			.extreme_init(extreme_q),
			.change_min  (change_q),
			.stat        (stat[a])
		);
	end

	asd_select u_select (
		.stat(stat),
		.sel (sel),
		.thr (sel_thr),
		.step(step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			step_q <= step;
			axis_q <= sel;
			thr_q  <= sel_thr;
		end
	end

	assign out_valid        = out_valid_q;
	assign step_seen        = step_q;
	assign active_axis      = axis_q;
	assign active_threshold = thr_q;

endmodule

[bench/accel_step_detector_test.sv]
`timescale 1ns / 1ps

module accel_step_detector_test;
	import asd_pkg::*;

	localparam int TAPS = SUM_TAPS_DEF;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT = 400;
	localparam int MAX_PRINTED = 40;
	localparam cfg_index_t CFG_SPARE = 2'd3;
	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	typedef enum int {SIG_WAVE, SIG_FULL, SIG_RAIL, SIG_QUIET} signal_mode_t;

	typedef struct {
		logic       step;
		axis_code_t axis;
		val_t       thr;
	} step_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	sample_t               accel_x;
	sample_t               accel_y;
	sample_t               accel_z;
	logic                  out_valid;
	logic                  out_ready;
	logic                  step_seen;
	axis_code_t            active_axis;
	val_t                  active_threshold;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	accel_step_detector #(
		.SUM_TAPS(TAPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.step_seen(step_seen),
		.active_axis(active_axis),
		.active_threshold(active_threshold),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the detector state and its settings
	sample_t             accel_hist [AXES][TAPS];
	int                  peak_hi [AXES];
	int                  peak_lo [AXES];
	int                  axis_thr [AXES];
	int                  filt_now [AXES];
	int                  filt_prev [AXES];
	logic [WINDOW_W-1:0] win_count;
	logic [WINDOW_W-1:0] set_window;
	logic [EXT_W-1:0]    set_extreme;
	logic [EXT_W-1:0]    set_change;

	step_result_t steps_due [$];
	int           mismatch_count = 0;
	int           idle_cycles = 0;
	bit           flood = 1'b0;
	bit           quiet_in = 1'b0;
	bit           quiet_out = 1'b0;

	function automatic int clamp(int v, int lo, int hi);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic void reset_shadow();
		for (int a = 0; a < AXES; a++) begin
			for (int k = 0; k < TAPS; k++)
				accel_hist[a][k] = '0;
			peak_hi[a] = 0;
			peak_lo[a] = 0;
			axis_thr[a] = 0;
			filt_now[a] = 0;
			filt_prev[a] = 0;
		end
		win_count = '0;
		set_window = WINDOW_RESET;
		set_extreme = EXTREME_RESET;
		set_change = CHANGE_RESET;
	endfunction

	function automatic step_result_t detect_step(sample_t x, sample_t y, sample_t z);
		sample_t      fresh [AXES];
		int           sum [AXES];
		int           mag [AXES];
		int           acc;
		int           cnt;
		int           diff;
		axis_code_t   sel;
		step_result_t r;
		fresh[0] = x;
		fresh[1] = y;
		fresh[2] = z;
		for (int a = 0; a < AXES; a++) begin
			for (int k = TAPS - 1; k > 0; k--)
				accel_hist[a][k] = accel_hist[a][k - 1];
			accel_hist[a][0] = fresh[a];
			acc = 0;
			for (int k = 0; k < TAPS; k++)
				acc += accel_hist[a][k];
			sum[a] = clamp(acc, VAL_MIN, VAL_MAX);
			if (sum[a] > peak_hi[a]) peak_hi[a] = sum[a];
			if (sum[a] < peak_lo[a]) peak_lo[a] = sum[a];
		end

		// counter is compared one bit wider than it is stored
		cnt = int'(win_count) + 1;
		if (cnt > int'(set_window)) begin
			cnt = 0;
			for (int a = 0; a < AXES; a++) begin
				axis_thr[a] = (peak_hi[a] + peak_lo[a]) / 2;
				peak_hi[a] = -int'(set_extreme);
				peak_lo[a] = int'(set_extreme);
			end
		end
		win_count = cnt[WINDOW_W-1:0];

		for (int a = 0; a < AXES; a++) begin
			filt_prev[a] = filt_now[a];
			diff = filt_now[a] - sum[a];
			if (diff < 0) diff = -diff;
			if (diff > int'(set_change)) filt_now[a] = sum[a];
			mag[a] = (axis_thr[a] < 0) ? -axis_thr[a] : axis_thr[a];
		end

		if (mag[0] > mag[1]) sel = (mag[0] > mag[2]) ? AXIS_X : AXIS_Z;
		else sel = (mag[1] > mag[2]) ? AXIS_Y : AXIS_Z;

		r.step = (filt_prev[sel] > axis_thr[sel]) && (filt_now[sel] < axis_thr[sel]);
		r.axis = sel;
		r.thr = val_t'(axis_thr[sel]);
		return r;
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("[%0t] %s", $time, what);
	endtask

	task automatic send_sample(sample_t x, sample_t y, sample_t z);
		int gap;
		if (!flood && $urandom_range(0, 29) == 0) quiet_in = !quiet_in;
		gap = (flood || quiet_in) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		do @(posedge clk); while (!in_ready);
		steps_due.push_back(detect_step(x, y, z));
	endtask

	// drop valid, let every result drain, then give the pipeline time to empty
	task automatic settle_block();
		in_valid <= 1'b0;
		while (steps_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_transfer(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WINDOW: begin
				set_window = data[WINDOW_W-1:0];
			end
			CFG_EXTREME: begin
				set_extreme = data;
			end
			CFG_CHANGE: begin
				set_change = data;
			end
			default: begin
			end
		endcase
	endtask

	task automatic write_settings(logic [CFG_DATA_W-1:0] window_word,
			logic [CFG_DATA_W-1:0] extreme, logic [CFG_DATA_W-1:0] change,
			bit poke_spare);
		settle_block();
		cfg_transfer(CFG_WINDOW, window_word);
		cfg_transfer(CFG_EXTREME, extreme);
		cfg_transfer(CFG_CHANGE, change);
		if (poke_spare)
			cfg_transfer(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 131071)));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_signal_phase(int count, signal_mode_t mode);
		int      amp [AXES];
		int      period [AXES];
		int      offset [AXES];
		int      shift [AXES];
		int      noise;
		int      p;
		int      ramp;
		int      v;
		sample_t s [AXES];
		for (int a = 0; a < AXES; a++) begin
			amp[a] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
				: $urandom_range(200, 12000);
			period[a] = $urandom_range(4, 60);
			offset[a] = int'($urandom_range(0, 16000)) - 8000;
			shift[a] = $urandom_range(0, 59);
		end
		noise = $urandom_range(0, 300);
		for (int t = 0; t < count; t++) begin
			for (int a = 0; a < AXES; a++) begin
				case (mode)
					SIG_WAVE: begin
						if ($urandom_range(0, 9) == 0) begin
							v = int'($urandom_range(0, 65535)) - 32768;
						end else begin
							p = (t + shift[a]) % period[a];
							ramp = (2 * p < period[a]) ? p : period[a] - p;
							v = offset[a] + amp[a] * (4 * ramp - period[a]) / period[a]
								+ int'($urandom_range(0, 2 * noise)) - noise;
						end
					end
					SIG_FULL: begin
						v = int'($urandom_range(0, 65535)) - 32768;
					end
					SIG_RAIL: begin
						case ($urandom_range(0, 3))
							0: v = -32768;
							1: v = -1;
							2: v = 0;
							default: v = 32767;
						endcase
					end
					default: begin
						v = int'($urandom_range(0, 127)) - 64;
					end
				endcase
				s[a] = sample_t'(clamp(v, -32768, 32767));
			end
			send_sample(s[0], s[1], s[2]);
			// hold off the sender until the detector has caught up
			if (t == count / 2) settle_block();
		end
	endtask

	task automatic test_reset_defaults();
		repeat (4) send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		repeat (4) send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
		send_sample(SAMPLE_MAX, SAMPLE_MIN, 16'sd0);
	endtask

	// window zero reloads on every sample, with a zero extreme and no dead band: threshold tracks half of every sum
	task automatic test_window_zero();
		write_settings('0, '0, '0, 1'b0);
		repeat (2) send_sample(16'sd0, 16'sd0, 16'sd0);
		repeat (3) send_sample(16'sd20000, 16'sd0, 16'sd0);
		repeat (2) send_sample(SAMPLE_MIN, 16'sd0, 16'sd0);
		repeat (4) send_sample(16'sd8000, 16'sd8000, 16'sd0);
		repeat (4) send_sample(16'sd9000, 16'sd0, 16'sd9000);
	endtask

	task automatic test_random_signals();
		logic [CFG_DATA_W-1:0] wd;
		logic [CFG_DATA_W-1:0] ed;
		logic [CFG_DATA_W-1:0] cd;
		signal_mode_t          mode;
		int                    pick;
		for (int ph = 0; ph < 8; ph++) begin
			wd = CFG_DATA_W'($urandom_range(1, 80));
			wd[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
			ed = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 131071))
				: CFG_DATA_W'($urandom_range(0, 3000));
			cd = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 131071))
				: CFG_DATA_W'($urandom_range(0, 1500));
			case (ph)
				0: write_settings(17'd1, '0, '0, 1'b0);
				1: write_settings(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b1);
				2: write_settings('0, ed, CFG_DATA_W'($urandom_range(0, 300)), 1'b0);
				3: write_settings(wd, 17'h1FFFF, '0, 1'b0);
				default: write_settings(wd, ed, cd, ph == 5);
			endcase
			pick = $urandom_range(0, 19);
			if (ph == 0 || pick < 12) mode = SIG_WAVE;
			else if (pick < 15) mode = SIG_FULL;
			else if (pick < 18) mode = SIG_RAIL;
			else mode = SIG_QUIET;
			run_signal_phase(200, mode);
		end
	endtask

	// largest window: the wide compare never fires, so thresholds hold all run
	task automatic test_counter_top();
		write_settings(17'h0FFFF, CFG_DATA_W'($urandom_range(0, 500)), '0, 1'b0);
		flood = 1'b1;
		for (int i = 0; i < 200; i++)
			send_sample(sample_t'(int'($urandom_range(0, 4000)) - 2000),
				sample_t'(int'($urandom_range(0, 4000)) - 2000),
				sample_t'(int'($urandom_range(0, 4000)) - 2000));
		flood = 1'b0;
	endtask

	initial begin : result_check
		step_result_t due;
		int           hold;
		out_ready = 1'b0;
		forever begin
			if (!flood && $urandom_range(0, 29) == 0) quiet_out = !quiet_out;
			hold = (flood || quiet_out) ? 0 : $urandom_range(0, 11);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (steps_due.size() == 0) begin
				report_mismatch("result transfer with no sample pending");
			end else begin
				due = steps_due.pop_front();
				if (step_seen !== due.step)
					report_mismatch($sformatf("step_seen %0b, predicted %0b",
						step_seen, due.step));
				if (active_axis !== due.axis)
					report_mismatch($sformatf("active_axis %0d, predicted %0d",
						active_axis, due.axis));
				if (active_threshold !== due.thr)
					report_mismatch($sformatf("active_threshold %0d, predicted %0d",
						active_threshold, due.thr));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("accel_step_detector: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_WINDOW;
		cfg_data = '0;
		reset_shadow();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_window_zero();
		test_random_signals();
		test_counter_top();
		settle_block();
		if (mismatch_count == 0)
			$display("accel_step_detector: match");
		else
			$display("accel_step_detector: mismatch");
		$finish;
	end

endmodule

[accel_step_detector.f]
design/asd_pkg.sv
design/asd_axis.sv
design/asd_select.sv
design/accel_step_detector.sv
bench/accel_step_detector_test.sv
